>>> src/h2n_pkg.sv
// Shared types, constants and arithmetic step functions for the height-to-normal pipeline.
// No dependencies; imported by height_to_normal_map and its testbench.
`timescale 1ns / 1ps

package h2n_pkg;

    // Configuration register indexes
    localparam logic REG_COLS_IN_USE = 1'b0;
    localparam logic REG_ROWS_IN_USE = 1'b1;

    // Item kinds carried on s_tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [8:0]  MIN_SIZE   = 9'd4;     // smallest image side
    localparam logic [8:0]  NBR_OFFSET = 9'd3;     // neighbor distance, left and up
    localparam logic [13:0] SCALE_SQ   = 14'd10000; // 100 squared
    localparam logic [16:0] S_BIAS     = 17'd100;  // z component squared (10*10)
    localparam logic [29:0] T_Z        = 30'd1000000; // 10000 * 10 * 10
    localparam logic [7:0]  MID        = 8'd128;
    localparam logic [13:0] Q_MAX      = 14'd10000;
    localparam logic [7:0]  ROOT_MAX   = 8'd100;
    localparam logic [7:0]  BYTE_LO    = 8'd28;
    localparam logic [7:0]  BYTE_HI    = 8'd228;

    localparam int DIV_BITS    = 14;  // quotient bits
    localparam int DIV_STEPS   = 2;   // quotient bits per stage
    localparam int DIV_STAGES  = DIV_BITS / DIV_STEPS;
    localparam int SQRT_STEPS  = 2;   // root bits per stage
    localparam int SQRT_STAGES = 8 / SQRT_STEPS;

    // Input register stage
    typedef struct packed {
        logic       valid;
        logic       op;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] hb;
    } in_stage_t;

    // Position reduction modulo image size
    typedef struct packed {
        logic       valid;
        logic       op;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] hb;
        logic [8:0] rem_c;
        logic [8:0] rem_r;
    } mod_stage_t;

    typedef struct packed {
        logic       valid;
        logic       neg_x;
        logic       neg_y;
        logic [7:0] abs_x;
        logic [7:0] abs_y;
    } diff_stage_t;

    typedef struct packed {
        logic        valid;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] sq_x;
        logic [15:0] sq_y;
    } sq_stage_t;

    // One restoring divider lane: partial remainder, unused dividend bits, quotient
    typedef struct packed {
        logic [16:0] rem;
        logic [13:0] lo;
        logic [13:0] q;
    } div_lane_t;

    typedef struct packed {
        logic        valid;
        logic        neg_x;
        logic        neg_y;
        logic [16:0] s;
        div_lane_t   lx;
        div_lane_t   ly;
        div_lane_t   lz;
    } div_stage_t;

    // One digit-by-digit square root lane
    typedef struct packed {
        logic [15:0] rad;
        logic [7:0]  root;
        logic [10:0] rem;
    } sqrt_lane_t;

    typedef struct packed {
        logic       valid;
        logic       neg_x;
        logic       neg_y;
        logic       rz_x;   // division remainder was zero
        logic       rz_y;
        sqrt_lane_t lx;
        sqrt_lane_t ly;
        sqrt_lane_t lz;
    } sqrt_stage_t;

    // rem < n on entry; returns ({rem,b}) mod n
    function automatic logic [8:0] mod_step(input logic [8:0] rem, input logic b,
                                            input logic [8:0] n);
        logic [9:0] x;
        x = {rem, b};
        if (x >= {1'b0, n})
            return 9'(x - {1'b0, n});
        return x[8:0];
    endfunction

    function automatic div_lane_t div_step(input div_lane_t ln, input logic [16:0] s);
        logic [17:0] x;
        div_lane_t   o;
        x = {ln.rem, ln.lo[13]};
        o.lo = {ln.lo[12:0], 1'b0};
        if (x >= {1'b0, s})
        begin
            o.rem = 17'(x - {1'b0, s});
            o.q   = {ln.q[12:0], 1'b1};
        end
        else
        begin
            o.rem = x[16:0];
            o.q   = {ln.q[12:0], 1'b0};
        end
        return o;
    endfunction

    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t ln);
        logic [10:0] x;
        logic [10:0] trial;
        sqrt_lane_t  o;
        x     = {ln.rem[8:0], ln.rad[15:14]};
        trial = {1'b0, ln.root, 2'b01};
        o.rad = {ln.rad[13:0], 2'b00};
        if (x >= trial)
        begin
            o.rem  = x - trial;
            o.root = {ln.root[6:0], 1'b1};
        end
        else
        begin
            o.rem  = x;
            o.root = {ln.root[6:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> src/height_to_normal_map.sv
// Height map store and normal map pipeline (top level).
// Depends on h2n_pkg for stage types, constants and divider/root step functions.
`timescale 1ns / 1ps
//
//  channel | signals                                  | accepted when
//  --------+------------------------------------------+------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser        | s_tvalid && s_tready
//  m_      | m_tvalid m_tready m_tdata                | m_tvalid && m_tready
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data   | cfg_valid && cfg_ready
//
//  One item enters per cycle while the pipeline is not stalled; a compute result shows on
//  m_tvalid after passing 21 registers (input, 2 modulo, address, memory read, difference,
//  square, 8 divider = scale + 7 x 2 quotient bits, 5 root = load + 4 x 2 root bits, output).
//  A load item writes the store in the memory-read stage and produces no result.
//  Reset clears valid bits and sets both sizes to their maximum; the store is not cleared.
//  The whole pipeline stalls only while the output register holds an untaken result.

module height_to_normal_map #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] col, [15:8] row, [23:16] height_byte
    input  logic        s_tuser,   // [0] op: 0 load, 1 compute
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] normal_x, [15:8] normal_y, [23:16] normal_z
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    import h2n_pkg::*;

    localparam int MEM_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [8:0] COLS_RESET = 9'((MAX_COLS < 256) ? MAX_COLS : 256);
    localparam logic [8:0] ROWS_RESET = 9'((MAX_ROWS < 256) ? MAX_ROWS : 256);

    // clamp an image side to 4..hi
    function automatic logic [8:0] sat_size(input logic [8:0] v, input int hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (int'(v) > hi)
            return 9'(hi);
        return v;
    endfunction

    function automatic logic [AW-1:0] pix_addr(input logic [8:0] r, input logic [8:0] c);
        return AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    // ---------------------------------------------------------------- configuration
    logic [8:0] cols_in_use_reg, cols_in_use_next;
    logic [8:0] rows_in_use_reg, rows_in_use_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cols_in_use_next = cols_in_use_reg;
        rows_in_use_next = rows_in_use_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COLS_IN_USE: cols_in_use_next = sat_size(cfg_data, MAX_COLS);
                REG_ROWS_IN_USE: rows_in_use_next = sat_size(cfg_data, MAX_ROWS);
                default:         cols_in_use_next = cols_in_use_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_in_use_reg <= COLS_RESET;
            rows_in_use_reg <= ROWS_RESET;
        end
        else
        begin
            cols_in_use_reg <= cols_in_use_next;
            rows_in_use_reg <= rows_in_use_next;
        end
    end

    // ---------------------------------------------------------------- pipeline control
    logic adv;   // every stage moves one step
    logic out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    in_stage_t   a_reg, a_next;
    mod_stage_t  b_reg, b_next;
    mod_stage_t  c_reg, c_next;

    logic          d_valid_reg, d_valid_next;   // compute item
    logic          d_we_reg, d_we_next;         // load item inside the store
    logic [7:0]    d_hb_reg, d_hb_next;
    logic [AW-1:0] d_addr_here_reg, d_addr_here_next;
    logic [AW-1:0] d_addr_left_reg, d_addr_left_next;
    logic [AW-1:0] d_addr_up_reg, d_addr_up_next;

    logic          e_valid_reg;
    logic [7:0]    e_h0_reg, e_hs_reg, e_ht_reg;  // raw bytes read from the store

    diff_stage_t f_reg, f_next;
    sq_stage_t   g_reg, g_next;
    div_stage_t  div_reg  [DIV_STAGES+1];
    div_stage_t  div_next [DIV_STAGES+1];
    sqrt_stage_t sq_reg   [SQRT_STAGES+1];
    sqrt_stage_t sq_next  [SQRT_STAGES+1];

    // input register
    always_comb
    begin
        a_next.valid = s_tvalid;
        a_next.op    = s_tuser;
        a_next.col   = s_tdata[7:0];
        a_next.row   = s_tdata[15:8];
        a_next.hb    = s_tdata[23:16];
    end

    // col mod cols, row mod rows: high nibble, then low nibble
    always_comb
    begin
        b_next.valid = a_reg.valid;
        b_next.op    = a_reg.op;
        b_next.col   = a_reg.col;
        b_next.row   = a_reg.row;
        b_next.hb    = a_reg.hb;
        b_next.rem_c = '0;
        b_next.rem_r = '0;
        for (int j = 0; j < 4; j++)
        begin
            b_next.rem_c = mod_step(b_next.rem_c, a_reg.col[7-j], cols_in_use_reg);
            b_next.rem_r = mod_step(b_next.rem_r, a_reg.row[7-j], rows_in_use_reg);
        end
        c_next = b_reg;
        for (int j = 0; j < 4; j++)
        begin
            c_next.rem_c = mod_step(c_next.rem_c, b_reg.col[3-j], cols_in_use_reg);
            c_next.rem_r = mod_step(c_next.rem_r, b_reg.row[3-j], rows_in_use_reg);
        end
    end

    // neighbor positions with wrap, store addresses
    always_comb
    begin
        logic [8:0] cl;
        logic [8:0] ru;
        if (c_reg.rem_c >= NBR_OFFSET)
            cl = c_reg.rem_c - NBR_OFFSET;
        else
            cl = 9'(c_reg.rem_c + cols_in_use_reg - NBR_OFFSET);
        if (c_reg.rem_r >= NBR_OFFSET)
            ru = c_reg.rem_r - NBR_OFFSET;
        else
            ru = 9'(c_reg.rem_r + rows_in_use_reg - NBR_OFFSET);

        d_valid_next = c_reg.valid && (c_reg.op == OP_COMPUTE);
        d_we_next    = c_reg.valid && (c_reg.op == OP_LOAD)
                       && (int'(c_reg.col) < MAX_COLS) && (int'(c_reg.row) < MAX_ROWS);
        d_hb_next    = c_reg.hb;
        if (c_reg.op == OP_COMPUTE)
            d_addr_here_next = pix_addr(c_reg.rem_r, c_reg.rem_c);
        else
            d_addr_here_next = pix_addr({1'b0, c_reg.row}, {1'b0, c_reg.col});
        d_addr_left_next = pix_addr(c_reg.rem_r, cl);
        d_addr_up_next   = pix_addr(ru, c_reg.rem_c);
    end

    // ---------------------------------------------------------------- height store
    // three copies, one read port each; loads write all of them in this same stage,
    // so reads and writes keep item order
    logic [7:0] here_mem [MEM_DEPTH];
    logic [7:0] left_mem [MEM_DEPTH];
    logic [7:0] up_mem   [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (d_we_reg)
                here_mem[d_addr_here_reg] <= d_hb_reg;
            e_h0_reg <= here_mem[d_addr_here_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (d_we_reg)
                left_mem[d_addr_here_reg] <= d_hb_reg;
            e_hs_reg <= left_mem[d_addr_left_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (d_we_reg)
                up_mem[d_addr_here_reg] <= d_hb_reg;
            e_ht_reg <= up_mem[d_addr_up_reg];
        end
    end

    // ---------------------------------------------------------------- arithmetic
    // inverted heights: dx = raw_here - raw_left; c = -dx is negative when dx > 0
    always_comb
    begin
        f_next.valid = e_valid_reg;
        f_next.neg_x = e_h0_reg > e_hs_reg;
        f_next.neg_y = e_h0_reg > e_ht_reg;
        f_next.abs_x = f_next.neg_x ? e_h0_reg - e_hs_reg : e_hs_reg - e_h0_reg;
        f_next.abs_y = f_next.neg_y ? e_h0_reg - e_ht_reg : e_ht_reg - e_h0_reg;

        g_next.valid = f_reg.valid;
        g_next.neg_x = f_reg.neg_x;
        g_next.neg_y = f_reg.neg_y;
        g_next.sq_x  = 16'(f_reg.abs_x) * 16'(f_reg.abs_x);
        g_next.sq_y  = 16'(f_reg.abs_y) * 16'(f_reg.abs_y);
    end

    // q = floor(10000*c^2 / S); t < 2^14 * S, so the top 16 bits start below S
    always_comb
    begin
        logic [29:0] t_x;
        logic [29:0] t_y;
        t_x = 30'(g_reg.sq_x) * 30'(SCALE_SQ);
        t_y = 30'(g_reg.sq_y) * 30'(SCALE_SQ);

        div_next[0].valid = g_reg.valid;
        div_next[0].neg_x = g_reg.neg_x;
        div_next[0].neg_y = g_reg.neg_y;
        div_next[0].s     = 17'(g_reg.sq_x) + 17'(g_reg.sq_y) + S_BIAS;
        div_next[0].lx    = '{rem: {1'b0, t_x[29:14]}, lo: t_x[13:0], q: '0};
        div_next[0].ly    = '{rem: {1'b0, t_y[29:14]}, lo: t_y[13:0], q: '0};
        div_next[0].lz    = '{rem: {1'b0, T_Z[29:14]}, lo: T_Z[13:0], q: '0};

        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            div_next[k] = div_reg[k-1];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                div_next[k].lx = div_step(div_next[k].lx, div_next[k].s);
                div_next[k].ly = div_step(div_next[k].ly, div_next[k].s);
                div_next[k].lz = div_step(div_next[k].lz, div_next[k].s);
            end
        end
    end

    // k = isqrt(q); the result is exact when both remainders are zero
    always_comb
    begin
        sq_next[0].valid = div_reg[DIV_STAGES].valid;
        sq_next[0].neg_x = div_reg[DIV_STAGES].neg_x;
        sq_next[0].neg_y = div_reg[DIV_STAGES].neg_y;
        sq_next[0].rz_x  = div_reg[DIV_STAGES].lx.rem == '0;
        sq_next[0].rz_y  = div_reg[DIV_STAGES].ly.rem == '0;
        sq_next[0].lx    = '{rad: {2'b00, div_reg[DIV_STAGES].lx.q}, root: '0, rem: '0};
        sq_next[0].ly    = '{rad: {2'b00, div_reg[DIV_STAGES].ly.q}, root: '0, rem: '0};
        sq_next[0].lz    = '{rad: {2'b00, div_reg[DIV_STAGES].lz.q}, root: '0, rem: '0};

        for (int k = 1; k <= SQRT_STAGES; k++)
        begin
            sq_next[k] = sq_reg[k-1];
            for (int j = 0; j < SQRT_STEPS; j++)
            begin
                sq_next[k].lx = sqrt_step(sq_next[k].lx);
                sq_next[k].ly = sqrt_step(sq_next[k].ly);
                sq_next[k].lz = sqrt_step(sq_next[k].lz);
            end
        end
    end

    // floor for positive c, ceiling of the magnitude for negative c
    always_comb
    begin
        logic       exact_x;
        logic       exact_y;
        logic [7:0] nx;
        logic [7:0] ny;
        exact_x = sq_reg[SQRT_STAGES].rz_x && (sq_reg[SQRT_STAGES].lx.rem == '0);
        exact_y = sq_reg[SQRT_STAGES].rz_y && (sq_reg[SQRT_STAGES].ly.rem == '0);
        if (sq_reg[SQRT_STAGES].neg_x)
            nx = MID - sq_reg[SQRT_STAGES].lx.root - {7'b0, !exact_x};
        else
            nx = MID + sq_reg[SQRT_STAGES].lx.root;
        if (sq_reg[SQRT_STAGES].neg_y)
            ny = MID - sq_reg[SQRT_STAGES].ly.root - {7'b0, !exact_y};
        else
            ny = MID + sq_reg[SQRT_STAGES].ly.root;
        out_valid_next = sq_reg[SQRT_STAGES].valid;
        out_data_next  = {MID + sq_reg[SQRT_STAGES].lz.root, ny, nx};
    end

    // ---------------------------------------------------------------- stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg           <= '0;
            b_reg           <= '0;
            c_reg           <= '0;
            d_valid_reg     <= 1'b0;
            d_we_reg        <= 1'b0;
            d_hb_reg        <= '0;
            d_addr_here_reg <= '0;
            d_addr_left_reg <= '0;
            d_addr_up_reg   <= '0;
            e_valid_reg     <= 1'b0;
            f_reg           <= '0;
            g_reg           <= '0;
            for (int k = 0; k <= DIV_STAGES; k++)
                div_reg[k] <= '0;
            for (int k = 0; k <= SQRT_STAGES; k++)
                sq_reg[k] <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else if (adv)
        begin
            a_reg           <= a_next;
            b_reg           <= b_next;
            c_reg           <= c_next;
            d_valid_reg     <= d_valid_next;
            d_we_reg        <= d_we_next;
            d_hb_reg        <= d_hb_next;
            d_addr_here_reg <= d_addr_here_next;
            d_addr_left_reg <= d_addr_left_next;
            d_addr_up_reg   <= d_addr_up_next;
            e_valid_reg     <= d_valid_reg;
            f_reg           <= f_next;
            g_reg           <= g_next;
            for (int k = 0; k <= DIV_STAGES; k++)
                div_reg[k] <= div_next[k];
            for (int k = 0; k <= SQRT_STAGES; k++)
                sq_reg[k] <= sq_next[k];
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // input side stalls only behind an untaken result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // a stalled pipeline keeps its first stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(a_reg))
        else $error("input stage changed during a stall");

    // quotient never exceeds 100^2, root never exceeds 100
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_reg[DIV_STAGES].valid |->
            (div_reg[DIV_STAGES].lx.q <= Q_MAX) && (div_reg[DIV_STAGES].ly.q <= Q_MAX)
            && (div_reg[DIV_STAGES].lz.q <= Q_MAX))
        else $error("divider quotient out of range");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sq_reg[SQRT_STAGES].valid |->
            (sq_reg[SQRT_STAGES].lx.root <= ROOT_MAX)
            && (sq_reg[SQRT_STAGES].ly.root <= ROOT_MAX)
            && (sq_reg[SQRT_STAGES].lz.root <= ROOT_MAX))
        else $error("root out of range");

    // result bytes stay in their ranges
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (m_tdata[7:0] >= BYTE_LO) && (m_tdata[7:0] <= BYTE_HI)
            && (m_tdata[15:8] >= BYTE_LO) && (m_tdata[15:8] <= BYTE_HI)
            && (m_tdata[23:16] >= MID) && (m_tdata[23:16] <= BYTE_HI))
        else $error("normal byte out of range");
`endif

endmodule

>>> bench/height_to_normal_map_tb.sv
// Self-checking testbench for height_to_normal_map: loads height tiles, requests normals,
// and checks every result against an in-bench integer predictor. Uses h2n_pkg register codes.
`timescale 1ns / 1ps

module height_to_normal_map_tb;

    import h2n_pkg::*;

    localparam int STORE_COLS   = 256;
    localparam int STORE_ROWS   = 256;
    localparam int PIPE_LATENCY = 20;               // accept-to-result, input register to output register
    localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY; // slack after the last result
    localparam int STALL_CYCLES = 250;              // long receiver hold-off
    localparam int MAX_PRINTS   = 40;

    // 4x4 tile for the directed part, byte index = row*4 + col.
    // Laid out so that flat spots, both full-scale slopes and mid values all occur.
    localparam logic [127:0] DIRECTED_TILE = 128'h00FFFF00_078000FF_FF00FF00_00FF0000;

    typedef struct packed {
        logic [7:0] nz;
        logic [7:0] ny;
        logic [7:0] nx;
    } normal_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    height_to_normal_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] col, [15:8] row, [23:16] height_byte
        .s_tuser   (s_tuser),     // [0] op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] normal_x, [15:8] normal_y, [23:16] normal_z
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the height store and the size registers.
    // height_written tracks which entries hold data, so that no compute ever
    // touches an entry the block was never given.
    // ------------------------------------------------------------------
    logic [7:0] height_copy    [0:STORE_COLS*STORE_ROWS-1];
    bit         height_written [0:STORE_COLS*STORE_ROWS-1];
    logic [8:0] cols_cfg = 9'd256;
    logic [8:0] rows_cfg = 9'd256;

    normal_t normal_q[$];   // expected normals, oldest first

    int err_count  = 0;
    int n_loads    = 0;
    int n_computes = 0;
    int n_checked  = 0;
    int n_cfg      = 0;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int stall_req    = 0;    // hold-off length requested of the receiver
    bit stall_active = 1'b0;

    // Outputs are sampled at the falling edge; inputs only move at the rising
    // edge, so these copies equal what the block sees at the next rising edge.
    logic    in_ready_seen  = 1'b0;
    logic    cfg_ready_seen = 1'b0;
    logic    out_valid_seen = 1'b0;
    normal_t out_data_seen;

    normal_t got_normal;
    normal_t want_normal;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        in_ready_seen  = s_tready;
        cfg_ready_seen = cfg_ready;
        out_valid_seen = m_tvalid;
        out_data_seen  = m_tdata;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int clamp_size(input logic [8:0] v, input int hi);
        if (v < 9'd4)
            return 4;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // floor(128 + 100*c/sqrt(s)) without floating point; rounds toward -inf for c < 0
    function automatic logic [7:0] normal_byte(input int c, input longint s);
        longint a;
        longint t;
        longint k;
        a = (c < 0) ? -c : c;
        t = 64'd10000 * a * a;
        k = 0;
        while ((k + 1) * (k + 1) * s <= t)
            k++;
        if (c >= 0)
            return 8'(128 + k);
        if (k * k * s != t)
            k++;
        return 8'(128 - k);
    endfunction

    function automatic normal_t predict_normal(input logic [7:0] col, input logic [7:0] row);
        int      nc;
        int      nr;
        int      c;
        int      r;
        int      cl;
        int      ru;
        int      h_here;
        int      h_left;
        int      h_up;
        int      dx;
        int      dy;
        longint  s;
        normal_t n;
        nc = clamp_size(cols_cfg, STORE_COLS);
        nr = clamp_size(rows_cfg, STORE_ROWS);
        c  = int'(col) % nc;
        r  = int'(row) % nr;
        cl = (c + nc - 3) % nc;     // left neighbor wraps to the far side
        ru = (r + nr - 3) % nr;
        h_here = 255 - int'(height_copy[r * STORE_COLS + c]);
        h_left = 255 - int'(height_copy[r * STORE_COLS + cl]);
        h_up   = 255 - int'(height_copy[ru * STORE_COLS + c]);
        dx = h_left - h_here;
        dy = h_up - h_here;
        s  = longint'(dx * dx) + longint'(dy * dy) + 100;
        n.nx = normal_byte(-dx, s);
        n.ny = normal_byte(-dy, s);
        n.nz = normal_byte(10, s);
        return n;
    endfunction

    function automatic logic [7:0] pick_height();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: one item per call. Leaves s_tvalid high so back-to-back
    // items stream without a bubble; wait_idle lowers it.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [7:0] col, input logic [7:0] row,
                             input logic [7:0] hb);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {hb, row, col};
        do @(posedge clk); while (!in_ready_seen);
        // accepted at this edge: update the predictor in item order
        if (op == OP_COMPUTE)
        begin
            normal_q.push_back(predict_normal(col, row));
            n_computes++;
        end
        else
        begin
            height_copy[int'(row) * STORE_COLS + int'(col)]    = hb;
            height_written[int'(row) * STORE_COLS + int'(col)] = 1'b1;
            n_loads++;
        end
    endtask

    // Stop offering, wait for every expected normal, then let trailing loads clear.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (normal_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_handshake();
        do @(posedge clk); while (!cfg_ready_seen);
        n_cfg++;
    endtask

    // Both size registers, written back to back while the block is idle.
    task automatic set_image_size(input logic [8:0] cols, input logic [8:0] rows);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_COLS_IN_USE;
        cfg_data  <= cols;
        cfg_handshake();
        cols_cfg = cols;
        cfg_index <= REG_ROWS_IN_USE;
        cfg_data  <= rows;
        cfg_handshake();
        rows_cfg = rows;
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_if_missing(input int c, input int r);
        if (!height_written[r * STORE_COLS + c])
            send_item(OP_LOAD, 8'(c), 8'(r), pick_height());
    endtask

    // A compute at a random spot, preceded by loads of any of its three taps not yet stored.
    // Half the coordinates are drawn from the whole byte range, to exercise the modulo reduction.
    task automatic random_compute();
        int         nc;
        int         nr;
        int         c;
        int         r;
        logic [7:0] col;
        logic [7:0] row;
        nc  = clamp_size(cols_cfg, STORE_COLS);
        nr  = clamp_size(rows_cfg, STORE_ROWS);
        col = $urandom_range(0, 1) ? 8'($urandom_range(0, nc - 1)) : 8'($urandom_range(0, 255));
        row = $urandom_range(0, 1) ? 8'($urandom_range(0, nr - 1)) : 8'($urandom_range(0, 255));
        c   = int'(col) % nc;
        r   = int'(row) % nr;
        fill_if_missing(c, r);
        fill_if_missing((c + nc - 3) % nc, r);
        fill_if_missing(c, (r + nr - 3) % nr);
        send_item(OP_COMPUTE, col, row, 8'($urandom_range(0, 255)));
    endtask

    // Overwrite a pixel, mostly inside the image in use, sometimes anywhere in the store.
    task automatic random_load();
        int nc;
        int nr;
        nc = clamp_size(cols_cfg, STORE_COLS);
        nr = clamp_size(rows_cfg, STORE_ROWS);
        if ($urandom_range(0, 3) != 0)
            send_item(OP_LOAD, 8'($urandom_range(0, nc - 1)), 8'($urandom_range(0, nr - 1)),
                      pick_height());
        else
            send_item(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      pick_height());
    endtask

    task automatic random_items(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 6)
                random_compute();
            else
                random_load();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest image: load a hand-made tile, then hit flat ground, full-scale slopes
    // both ways, left/up wrap and positions far outside the image.
    task automatic test_directed_small();
        int r;
        int c;
        set_image_size(9'd4, 9'd4);
        for (r = 0; r < 4; r++)
            for (c = 0; c < 4; c++)
                send_item(OP_LOAD, 8'(c), 8'(r), DIRECTED_TILE[(r * 4 + c) * 8 +: 8]);
        send_item(OP_COMPUTE, 8'd0,   8'd0,   8'hFF);  // flat
        send_item(OP_COMPUTE, 8'd1,   8'd0,   8'h00);  // steepest one way
        send_item(OP_COMPUTE, 8'd2,   8'd0,   8'hFF);  // steepest the other way
        send_item(OP_COMPUTE, 8'd2,   8'd2,   8'h00);
        send_item(OP_COMPUTE, 8'd3,   8'd3,   8'hFF);  // no wrap on either tap
        send_item(OP_COMPUTE, 8'd255, 8'd255, 8'h00);  // reduces to (3,3)
        send_item(OP_COMPUTE, 8'd6,   8'd9,   8'hFF);
        send_item(OP_COMPUTE, 8'd128, 8'd1,   8'h00);
    endtask

    // Register values below 4 and above 256 are clamped by the block.
    task automatic test_size_saturation();
        set_image_size(9'd0, 9'd511);
        random_items(20);
        set_image_size(9'd300, 9'd3);
        random_items(20);
    endtask

    task automatic test_random_sizes();
        int i;
        set_image_size(9'd4, 9'd4);
        random_items(60);
        set_image_size(9'd5, 9'd7);
        random_items(60);
        set_image_size(9'd16, 9'd16);
        random_items(50);
        set_image_size(9'd256, 9'd4);
        random_items(20);
        set_image_size(9'd4, 9'd256);
        random_items(20);
        set_image_size(9'd256, 9'd256);
        random_items(16);
        for (i = 0; i < 3; i++)
        begin
            // some phases run with one or both sides never idling
            src_idle_en  = ($urandom_range(0, 2) != 0);
            sink_idle_en = ($urandom_range(0, 2) != 0);
            set_image_size(9'($urandom_range(4, 32)), 9'($urandom_range(4, 32)));
            random_items(30);
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Receiver stops for a long stretch while items keep coming: the pipeline
    // must fill, stall its input, and lose nothing.
    task automatic test_output_stall();
        int i;
        set_image_size(9'd8, 9'd8);
        stall_req = STALL_CYCLES;
        wait (stall_active);
        for (i = 0; i < 60; i++)
            random_compute();
    endtask

    // Last part: full rate on both sides.
    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        set_image_size(9'd12, 9'd10);
        random_items(100);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready bursts, plus the long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_req > 0)
            begin
                m_tready <= 1'b0;
                stall_active = 1'b1;
                repeat (stall_req) @(posedge clk);
                stall_req    = 0;
                stall_active = 1'b0;
                m_tready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted normal against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tready && out_valid_seen)
        begin
            got_normal = out_data_seen;
            if (normal_q.size() == 0)
                report_mismatch($sformatf("result %h with nothing expected", got_normal));
            else
            begin
                want_normal = normal_q.pop_front();
                n_checked++;
                if (got_normal.nx !== want_normal.nx)
                    report_mismatch($sformatf("normal_x got %0d want %0d",
                                              got_normal.nx, want_normal.nx));
                if (got_normal.ny !== want_normal.ny)
                    report_mismatch($sformatf("normal_y got %0d want %0d",
                                              got_normal.ny, want_normal.ny));
                if (got_normal.nz !== want_normal.nz)
                    report_mismatch($sformatf("normal_z got %0d want %0d",
                                              got_normal.nz, want_normal.nz));
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("[%0t] timeout: %0d normals still expected", $realtime, normal_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_LOAD;
        cfg_valid = 1'b0;
        cfg_index = REG_COLS_IN_USE;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_small();
        test_size_saturation();
        test_random_sizes();
        test_output_stall();
        test_full_rate();

        wait_idle();
        if (normal_q.size() != 0)
            report_mismatch($sformatf("%0d normals never arrived", normal_q.size()));

        $display("Covered %0d loads and %0d computes over %0d register writes;",
                 n_loads, n_computes, n_cfg);
        $display("%0d normals checked, %0d mismatches.", n_checked, err_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
